[hdl/rhsv_pkg.sv]
// Shared types and constants for the RGB to HSV converter.
// Depends on nothing; used by the converter top level and its port checker.
`default_nettype none

package rhsv_pkg;

    // Field widths
    localparam int CH_W   = 8;   // one color channel
    localparam int HUE_W  = 15;  // hue in 1/64 degree
    localparam int SAT_W  = 8;   // saturation
    localparam int HP_W   = 11;  // hue offset H', below 6*255
    localparam int HDIV_W = 23;  // 3840*H' dividend
    localparam int SDIV_W = 16;  // 255*delta dividend

    // Long division: one quotient bit per step, hue needs the most bits
    localparam int NUM_STEPS = HUE_W;

    // Fixed-point scale factors
    localparam int HUE_SCALE = 3840;  // 60 degrees times 64
    localparam int SAT_SCALE = 255;
    localparam int HUE_MAX   = 23039; // 360*64 - 1

    // Sector of the largest channel, red wins ties over green, green over blue
    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } t_sector;

    // Input request payload
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_hsv_in;

    // Result payload
    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [CH_W-1:0]  brightness;
        logic             hue_defined;
    } t_hsv_out;

endpackage

`default_nettype wire

[hdl/rgb_to_hsv_converter_unit.sv]
// RGB to HSV converter top level: min/max stage, dividend stage, 15 division steps.
// Depends on rhsv_pkg for payload types, widths and scale constants.
//
// Usage:
//   Input channel i_valid/o_ready carries one t_hsv_in request (red, green, blue).
//   Output channel o_valid/i_ready carries one t_hsv_out result per request,
//   in request order.
// Depth: 17 register stages (min/max, dividends, 15 long-division steps);
//   an accepted request passes through each of them in order, and o_valid
//   rises once it reaches the last division-step register.
// Throughput: one pixel per clock while i_ready is high. Every stage holds a valid
//   bit and moves on when the stage after it is empty or moving, so bubbles
//   collapse. The depth is set by the 15-bit hue quotient, one restoring-division
//   bit per stage; the 8-bit saturation quotient runs in the last 8 of them.
// Reset: synchronous, active low; clears all stage valid bits, so the
//   pipeline comes up empty and o_ready high.
// Receiver stall: the last stage holds its result stable while i_ready is
//   low; earlier stages keep filling until every stage is full, then o_ready
//   drops. Nothing is lost or repeated.
`default_nettype none

module rgb_to_hsv_converter_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire rhsv_pkg::t_hsv_in i_pixel,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output rhsv_pkg::t_hsv_out     o_hsv
);
    import rhsv_pkg::*;

    // Stage A: channels plus their extremes
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] mn;
        t_sector         sector;
    } t_stage_a;

    // Dividend stage and every division step
    typedef struct packed {
        logic [HDIV_W-1:0] rem_h;
        logic [CH_W-1:0]   den_h;
        logic [HUE_W-1:0]  quo_h;
        logic [SDIV_W-1:0] rem_s;
        logic [CH_W-1:0]   den_s;
        logic [SAT_W-1:0]  quo_s;
        logic [CH_W-1:0]   brightness;
        logic              defined;
    } t_div;

    t_stage_a r_a, n_a;
    logic     r_va;
    t_div     r_b, n_b;
    logic     r_vb;

    t_div r_d   [NUM_STEPS];
    t_div n_d   [NUM_STEPS];
    logic r_vd  [NUM_STEPS];
    t_div w_src [NUM_STEPS];
    logic w_src_v [NUM_STEPS];
    logic w_rdy_d [NUM_STEPS];
    logic w_rdy_a, w_rdy_b;

    // Ready chain: a stage takes new data when empty or when it drains
    assign w_rdy_d[NUM_STEPS-1] = !r_vd[NUM_STEPS-1] || i_ready;
    for (genvar k = 0; k < NUM_STEPS - 1; k++) begin : g_rdy
        assign w_rdy_d[k] = !r_vd[k] || w_rdy_d[k+1];
    end
    assign w_rdy_b = !r_vb || w_rdy_d[0];
    assign w_rdy_a = !r_va || w_rdy_b;
    assign o_ready = w_rdy_a;

    // Stage A: find max, min and the sector of the max
    always_comb begin
        n_a.red   = i_pixel.red;
        n_a.green = i_pixel.green;
        n_a.blue  = i_pixel.blue;
        if (i_pixel.red >= i_pixel.green && i_pixel.red >= i_pixel.blue) begin
            n_a.sector = SECT_RED;
            n_a.mx     = i_pixel.red;
        end else if (i_pixel.green >= i_pixel.blue) begin
            n_a.sector = SECT_GREEN;
            n_a.mx     = i_pixel.green;
        end else begin
            n_a.sector = SECT_BLUE;
            n_a.mx     = i_pixel.blue;
        end
        if (i_pixel.red <= i_pixel.green && i_pixel.red <= i_pixel.blue) begin
            n_a.mn = i_pixel.red;
        end else if (i_pixel.green <= i_pixel.blue) begin
            n_a.mn = i_pixel.green;
        end else begin
            n_a.mn = i_pixel.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_rdy_a) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a && i_valid) begin
            r_a <= n_a;
        end
    end

    // Stage B: delta, hue offset H' and both dividends
    logic [CH_W-1:0]        w_delta;
    logic signed [HP_W:0]   w_r_s, w_g_s, w_b_s, w_d_s, w_hp_s;
    logic [HP_W-1:0]        w_hp;

    always_comb begin
        w_delta = r_a.mx - r_a.mn;
        w_r_s   = signed'({{(HP_W + 1 - CH_W){1'b0}}, r_a.red});
        w_g_s   = signed'({{(HP_W + 1 - CH_W){1'b0}}, r_a.green});
        w_b_s   = signed'({{(HP_W + 1 - CH_W){1'b0}}, r_a.blue});
        w_d_s   = signed'({{(HP_W + 1 - CH_W){1'b0}}, w_delta});
        case (r_a.sector)
            SECT_RED:   w_hp_s = w_g_s - w_b_s;
            SECT_GREEN: w_hp_s = (w_d_s <<< 1) + w_b_s - w_r_s;
            SECT_BLUE:  w_hp_s = (w_d_s <<< 2) + w_r_s - w_g_s;
            default:    w_hp_s = '0;
        endcase
        // Wrap a negative offset into the last sector
        if (w_hp_s < 0) begin
            w_hp_s = w_hp_s + (w_d_s <<< 2) + (w_d_s <<< 1);
        end
        w_hp = w_hp_s[HP_W-1:0];

        n_b.rem_h      = HDIV_W'(w_hp) * HDIV_W'(HUE_SCALE);
        n_b.den_h      = w_delta;
        n_b.quo_h      = '0;
        n_b.rem_s      = SDIV_W'(w_delta) * SDIV_W'(SAT_SCALE);
        n_b.den_s      = r_a.mx;
        n_b.quo_s      = '0;
        n_b.brightness = r_a.mx;
        n_b.defined    = (w_delta != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (w_rdy_b) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_b && r_va) begin
            r_b <= n_b;
        end
    end

    // Division steps: restoring long division, MSB first, one bit per stage
    assign w_src[0]   = r_b;
    assign w_src_v[0] = r_vb;
    for (genvar k = 1; k < NUM_STEPS; k++) begin : g_link
        assign w_src[k]   = r_d[k-1];
        assign w_src_v[k] = r_vd[k-1];
    end

    for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
        localparam int Bit = NUM_STEPS - 1 - k;

        logic [HDIV_W-1:0] w_sh_h;
        assign w_sh_h = HDIV_W'(w_src[k].den_h) << Bit;

        if (Bit < SAT_W) begin : g_sat
            logic [SDIV_W-1:0] w_sh_s;
            assign w_sh_s = SDIV_W'(w_src[k].den_s) << Bit;

            always_comb begin
                n_d[k] = w_src[k];
                if (w_src[k].rem_h >= w_sh_h) begin
                    n_d[k].rem_h      = w_src[k].rem_h - w_sh_h;
                    n_d[k].quo_h[Bit] = 1'b1;
                end
                if (w_src[k].rem_s >= w_sh_s) begin
                    n_d[k].rem_s      = w_src[k].rem_s - w_sh_s;
                    n_d[k].quo_s[Bit] = 1'b1;
                end
            end
        end else begin : g_hue_only
            always_comb begin
                n_d[k] = w_src[k];
                if (w_src[k].rem_h >= w_sh_h) begin
                    n_d[k].rem_h      = w_src[k].rem_h - w_sh_h;
                    n_d[k].quo_h[Bit] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[k] <= 1'b0;
            end else if (w_rdy_d[k]) begin
                r_vd[k] <= w_src_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy_d[k] && w_src_v[k]) begin
                r_d[k] <= n_d[k];
            end
        end
    end

    // Output: gray pixels report zero hue and saturation
    assign o_valid = r_vd[NUM_STEPS-1];
    always_comb begin
        o_hsv.brightness  = r_d[NUM_STEPS-1].brightness;
        o_hsv.hue_defined = r_d[NUM_STEPS-1].defined;
        if (r_d[NUM_STEPS-1].defined) begin
            o_hsv.hue        = r_d[NUM_STEPS-1].quo_h;
            o_hsv.saturation = r_d[NUM_STEPS-1].quo_s;
        end else begin
            o_hsv.hue        = '0;
            o_hsv.saturation = '0;
        end
    end

endmodule

`default_nettype wire

[hdl/rhsv_checker.sv]
// Port-level checker for the RGB to HSV converter, bound to its top level.
// Depends on rhsv_pkg for the payload types and the hue limit.
`default_nettype none

module rhsv_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire rhsv_pkg::t_hsv_in  i_pixel,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire rhsv_pkg::t_hsv_out o_hsv
);
    import rhsv_pkg::*;

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hsv))
        else $error("result changed or dropped while stalled");

    // Empty the pipeline on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Gray pixels carry zero hue and saturation
    a_gray_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hsv.hue_defined |-> o_hsv.hue == '0 && o_hsv.saturation == '0)
        else $error("gray pixel with nonzero hue or saturation");

    // Colored pixels: hue in range, nonzero saturation and brightness
    a_color_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hsv.hue_defined |->
            o_hsv.hue <= HUE_W'(HUE_MAX) && o_hsv.saturation != '0
            && o_hsv.brightness != '0)
        else $error("colored pixel result out of range");

endmodule

bind rgb_to_hsv_converter_unit rhsv_checker u_rhsv_checker (.*);

`default_nettype wire

[tb/tb_rgb_to_hsv_converter_unit.sv]
// Self-checking testbench for rgb_to_hsv_converter_unit: directed and random pixels,
// predicted in fixed point and compared field by field under random idle and stall.
// Depends on rhsv_pkg for the request and result payload types and scale constants.
`default_nettype none

module tb_rgb_to_hsv_converter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rhsv_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 24;      // a little beyond the 17-stage pipeline
    localparam int CYCLE_LIMIT  = 400000;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_ready = 1'b0;
    t_hsv_in  i_pixel = '0;
    logic     o_ready;
    logic     o_valid;
    t_hsv_out o_hsv;

    // Expected results in request order
    t_hsv_out expected_hsv_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    rgb_to_hsv_converter_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_hsv   (o_hsv)
    );

    // Generate the 100 MHz clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Compute hue, saturation and value of one pixel in exact fixed point
    function automatic t_hsv_out predict_hsv(input t_hsv_in px);
        int       r;
        int       g;
        int       b;
        int       vmax;
        int       vmin;
        int       delta;
        int       offset;
        t_sector  sector;
        t_hsv_out res;
        r = px.red;
        g = px.green;
        b = px.blue;
        vmax = r;
        vmin = r;
        if (g > vmax) vmax = g;
        if (b > vmax) vmax = b;
        if (g < vmin) vmin = g;
        if (b < vmin) vmin = b;
        delta = vmax - vmin;
        res.brightness = CH_W'(vmax);
        // Gray pixel: hue undefined
        if (delta == 0) begin
            res.hue         = '0;
            res.saturation  = '0;
            res.hue_defined = 1'b0;
            return res;
        end
        res.saturation = SAT_W'((SAT_SCALE * delta) / vmax);
        // Pick the sector, red wins ties over green, green over blue
        if (r == vmax) sector = SECT_RED;
        else if (g == vmax) sector = SECT_GREEN;
        else sector = SECT_BLUE;
        case (sector)
            SECT_RED:   offset = g - b;
            SECT_GREEN: offset = 2 * delta + (b - r);
            default:    offset = 4 * delta + (r - g);
        endcase
        if (offset < 0) offset += 6 * delta;
        res.hue         = HUE_W'((HUE_SCALE * offset) / delta);
        res.hue_defined = 1'b1;
        return res;
    endfunction

    // Build a random pixel, weighted toward gray, ties, tiny deltas and full range
    function automatic t_hsv_in random_pixel();
        logic [CH_W-1:0] ch[3];
        logic [CH_W-1:0] lvl;
        int              kind;
        int              pick;
        t_hsv_in         px;
        kind = $urandom_range(9);
        pick = $urandom_range(2);
        lvl  = CH_W'($urandom_range(255));
        for (int i = 0; i < 3; i++) ch[i] = CH_W'($urandom_range(255));
        case (kind)
            0: begin
                for (int i = 0; i < 3; i++) ch[i] = lvl;
            end
            1, 2: begin
                ch[pick]           = lvl;
                ch[(pick + 1) % 3] = lvl;
            end
            3: begin
                lvl = CH_W'($urandom_range(254));
                for (int i = 0; i < 3; i++) ch[i] = lvl + CH_W'($urandom_range(1));
            end
            4: begin
                ch[pick]           = '1;
                ch[(pick + 1) % 3] = '0;
            end
            default: ;
        endcase
        px.red   = ch[0];
        px.green = ch[1];
        px.blue  = ch[2];
        return px;
    endfunction

    // Offer one request, hold it until accepted, then record its expected result
    task automatic send_pixel(input t_hsv_in px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (!o_ready);
        expected_hsv_q.push_back(predict_hsv(px));
    endtask

    task automatic send_rgb(input int r, input int g, input int b);
        t_hsv_in px;
        px.red   = CH_W'(r);
        px.green = CH_W'(g);
        px.blue  = CH_W'(b);
        send_pixel(px);
    endtask

    // Drop valid and hold off until every expected result has come back
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_hsv_q.size() != 0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Check each accepted result and drive the receiver stall pattern
    always @(posedge i_clk) begin : check_results
        t_hsv_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_hsv_q.size() == 0) begin
                $error("unexpected result: hue %0d saturation %0d brightness %0d defined %0d",
                       o_hsv.hue, o_hsv.saturation, o_hsv.brightness, o_hsv.hue_defined);
                error_count++;
            end else begin
                want = expected_hsv_q.pop_front();
                check_field("hue", want.hue, o_hsv.hue);
                check_field("saturation", want.saturation, o_hsv.saturation);
                check_field("brightness", want.brightness, o_hsv.brightness);
                check_field("hue_defined", want.hue_defined, o_hsv.hue_defined);
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Gray pixels, channel extremes and tiny deltas
    task automatic test_gray_and_extremes();
        send_rgb(0, 0, 0);
        send_rgb(255, 255, 255);
        send_rgb(128, 128, 128);
        send_rgb(1, 0, 0);
        send_rgb(255, 254, 254);
        send_rgb(1, 1, 0);
        send_rgb(254, 1, 128);
        send_rgb(255, 0, 1);
    endtask

    // Every hue sector, the tie orders and the negative offset wrap
    task automatic test_hue_sectors();
        send_rgb(255, 0, 0);
        send_rgb(0, 255, 0);
        send_rgb(0, 0, 255);
        send_rgb(255, 255, 0);
        send_rgb(0, 255, 255);
        send_rgb(255, 0, 255);
        send_rgb(200, 10, 100);
        send_rgb(10, 200, 100);
        send_rgb(1, 2, 0);
        send_rgb(100, 10, 200);
        send_rgb(0, 1, 2);
    endtask

    task automatic test_random_stream(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct <= stall_pct;
        for (int n = 0; n < count; n++) send_pixel(random_pixel());
    endtask

    // Let the pipeline empty completely, then resume at full rate
    task automatic test_pause_until_drained();
        wait_for_drain();
        send_idle_pct = 0;
        for (int n = 0; n < 40; n++) send_pixel(random_pixel());
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_gray_and_extremes();
        test_hue_sectors();
        test_random_stream(0, 0, 480);
        test_pause_until_drained();
        test_random_stream(85, 0, 430);
        test_random_stream(0, 85, 430);
        test_random_stream(17, 17, 550);

        // Drain, then keep watching for stray results
        wait_for_drain();
        recv_stall_pct <= 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hdl/rhsv_pkg.sv
hdl/rgb_to_hsv_converter_unit.sv
hdl/rhsv_checker.sv
tb/tb_rgb_to_hsv_converter_unit.sv
